@@ rtl/core/sha256_message_digest_top_macros.svh @@
// Assertion macros for the digest core.
`ifndef SHA256_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_TOP_MACROS_SVH
`ifndef SYNTH
// implication in the same cycle
`define SHA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sha256 check failed");
// implication in the next cycle
`define SHA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sha256 check failed");
`else
`define SHA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SHA_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

@@ rtl/core/sha256md_pkg.sv @@
package sha256md_pkg;

  // byte source for the block shift register
  localparam logic [1:0] SEL_IN   = 2'd0;
  localparam logic [1:0] SEL_P80  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_W = 61;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t HASH_IV = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  typedef struct packed {
    logic       shift;      // shift one byte into the block
    logic [1:0] byte_sel;
    logic [2:0] len_pos;    // byte position within the length field
    logic       len_inc;
    logic       load_work;  // a..h <= hash
    logic       round;
    logic [5:0] rnd;
    logic       upd;        // hash += a..h
    logic       hash_init;  // back to IV, length cleared
    logic [2:0] word_sel;
  } sha256md_cmd_t;

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428A2F98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hB5C0FBCF;  6'd3:  round_k = 32'hE9B5DBA5;
      6'd4:  round_k = 32'h3956C25B;  6'd5:  round_k = 32'h59F111F1;
      6'd6:  round_k = 32'h923F82A4;  6'd7:  round_k = 32'hAB1C5ED5;
      6'd8:  round_k = 32'hD807AA98;  6'd9:  round_k = 32'h12835B01;
      6'd10: round_k = 32'h243185BE;  6'd11: round_k = 32'h550C7DC3;
      6'd12: round_k = 32'h72BE5D74;  6'd13: round_k = 32'h80DEB1FE;
      6'd14: round_k = 32'h9BDC06A7;  6'd15: round_k = 32'hC19BF174;
      6'd16: round_k = 32'hE49B69C1;  6'd17: round_k = 32'hEFBE4786;
      6'd18: round_k = 32'h0FC19DC6;  6'd19: round_k = 32'h240CA1CC;
      6'd20: round_k = 32'h2DE92C6F;  6'd21: round_k = 32'h4A7484AA;
      6'd22: round_k = 32'h5CB0A9DC;  6'd23: round_k = 32'h76F988DA;
      6'd24: round_k = 32'h983E5152;  6'd25: round_k = 32'hA831C66D;
      6'd26: round_k = 32'hB00327C8;  6'd27: round_k = 32'hBF597FC7;
      6'd28: round_k = 32'hC6E00BF3;  6'd29: round_k = 32'hD5A79147;
      6'd30: round_k = 32'h06CA6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27B70A85;  6'd33: round_k = 32'h2E1B2138;
      6'd34: round_k = 32'h4D2C6DFC;  6'd35: round_k = 32'h53380D13;
      6'd36: round_k = 32'h650A7354;  6'd37: round_k = 32'h766A0ABB;
      6'd38: round_k = 32'h81C2C92E;  6'd39: round_k = 32'h92722C85;
      6'd40: round_k = 32'hA2BFE8A1;  6'd41: round_k = 32'hA81A664B;
      6'd42: round_k = 32'hC24B8B70;  6'd43: round_k = 32'hC76C51A3;
      6'd44: round_k = 32'hD192E819;  6'd45: round_k = 32'hD6990624;
      6'd46: round_k = 32'hF40E3585;  6'd47: round_k = 32'h106AA070;
      6'd48: round_k = 32'h19A4C116;  6'd49: round_k = 32'h1E376C08;
      6'd50: round_k = 32'h2748774C;  6'd51: round_k = 32'h34B0BCB5;
      6'd52: round_k = 32'h391C0CB3;  6'd53: round_k = 32'h4ED8AA4A;
      6'd54: round_k = 32'h5B9CCA4F;  6'd55: round_k = 32'h682E6FF3;
      6'd56: round_k = 32'h748F82EE;  6'd57: round_k = 32'h78A5636F;
      6'd58: round_k = 32'h84C87814;  6'd59: round_k = 32'h8CC70208;
      6'd60: round_k = 32'h90BEFFFA;  6'd61: round_k = 32'hA4506CEB;
      6'd62: round_k = 32'hBEF9A3F7;  6'd63: round_k = 32'hC67178F2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

@@ rtl/core/sha256_message_digest_top.sv @@
// SHA-256 digest core, byte stream in, digest words out.
// Input channel s_*: one message byte per word; s_tlast marks the final byte,
//   s_tuser set ends a zero-length message (or the bytes so far) without a byte.
// Output channel m_*: eight 32-bit digest words per message, most significant
//   first; m_tuser carries the word index, m_tlast marks the eighth word.
// Throughput: one byte per cycle while a block fills, then the rounds
//   (one round per cycle in the shared round unit) and the hash update.
// Finish: padding shifts one byte per cycle up to the block end, then the final
//   block is compressed, and a second block of padding and length follows when
//   the length spills; the first digest word appears the cycle after the last
//   update.
// s_tready is low during rounds, hash update, padding and digest output.
// A stalled receiver holds the current digest word; the core waits and loses nothing.
// rst (synchronous, active high) returns to the initial hash with zero length;
//   no clearing pass is needed.
module sha256_message_digest_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  input  logic        s_tuser,   // [0] empty_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast,   // last_word
  output logic [2:0]  m_tuser    // [2:0] word_index
);
  import sha256md_pkg::*;

  sha256md_cmd_t cmd;

  // sequencer: fill count, padding flags, round and word counters
  sha256md_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cmd      (cmd)
  );

  // block/schedule register, working variables, hash and length
  sha256md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_byte     (s_tdata),
    .digest_word (m_tdata)
  );

endmodule

@@ rtl/core/sha256md_dp.sv @@
module sha256md_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  sha256md_pkg::sha256md_cmd_t cmd,
  input  logic [7:0]                  in_byte,
  output logic [31:0]                 digest_word
);
  import sha256md_pkg::*;

  logic [511:0]       blk;      // block bytes, later the rolling schedule; word 0 on top
  logic [31:0]        a, b, c, d, e, f, g, h;
  hash_t              hash;
  logic [LEN_W-1:0]   len;

  logic [7:0]  sel_byte;
  logic [63:0] bit_len;
  logic [63:0] len_shift;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2;

  assign bit_len   = {len, 3'b000};
  assign len_shift = bit_len >> {~cmd.len_pos, 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      SEL_IN:   sel_byte = in_byte;
      SEL_P80:  sel_byte = PAD_BYTE;
      SEL_LEN:  sel_byte = len_shift[7:0];
      default:  sel_byte = 8'h00;
    endcase
  end

  assign w0    = blk[511:480];
  assign w1    = blk[479:448];
  assign w9    = blk[223:192];
  assign w14   = blk[63:32];
  assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

  assign t1 = h + bsig1(e) + ((e & f) ^ (~e & g)) + round_k(cmd.rnd) + w0;
  assign t2 = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));

  assign digest_word = hash[cmd.word_sel];

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      blk <= {blk[503:0], sel_byte};
    end else if (cmd.round) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= hash[0]; b <= hash[1]; c <= hash[2]; d <= hash[3];
      e <= hash[4]; f <= hash[5]; g <= hash[6]; h <= hash[7];
    end else if (cmd.round) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.hash_init) begin
      hash <= HASH_IV;
      len  <= '0;
    end else begin
      if (cmd.upd) begin
        hash[0] <= hash[0] + a; hash[1] <= hash[1] + b;
        hash[2] <= hash[2] + c; hash[3] <= hash[3] + d;
        hash[4] <= hash[4] + e; hash[5] <= hash[5] + f;
        hash[6] <= hash[6] + g; hash[7] <= hash[7] + h;
      end
      if (cmd.len_inc && (len != '1)) begin
        len <= len + 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/sha256md_ctrl.sv @@
`include "sha256_message_digest_top_macros.svh"

module sha256md_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic                        s_tlast,
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic                        m_tlast,
  output logic [2:0]                  m_tuser,
  output sha256md_pkg::sha256md_cmd_t cmd
);
  import sha256md_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic [5:0] fill, fill_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;
  logic       fin, fin_next;         // message ended, finishing
  logic       sent80, sent80_next;   // pad marker placed
  logic       spill, spill_next;     // marker too late for the length in this block
  logic       lastblk, lastblk_next; // block under compression carries the length
  logic       acc;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (state == S_OUT) && (widx == 3'd7);
  assign m_tuser  = widx;

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    rnd_next     = rnd;
    widx_next    = widx;
    fin_next     = fin;
    sent80_next  = sent80;
    spill_next   = spill;
    lastblk_next = lastblk;
    cmd          = '0;
    cmd.rnd      = rnd;
    cmd.word_sel = widx;
    cmd.len_pos  = fill[2:0];
    cmd.byte_sel = SEL_IN;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (s_tuser) begin
            state_next = S_PAD;
            fin_next   = 1'b1;
          end else begin
            cmd.shift   = 1'b1;
            cmd.len_inc = 1'b1;
            fill_next   = fill + 6'd1;
            if (fill == 6'd63) begin
              cmd.load_work = 1'b1;
              state_next    = S_COMP;
              fin_next      = s_tlast;
              lastblk_next  = 1'b0;
            end else if (s_tlast) begin
              state_next = S_PAD;
              fin_next   = 1'b1;
            end
          end
        end
      end
      S_PAD: begin
        cmd.shift = 1'b1;
        fill_next = fill + 6'd1;
        if (!sent80) begin
          cmd.byte_sel = SEL_P80;
          sent80_next  = 1'b1;
          spill_next   = (fill[5:3] == 3'b111);
        end else if ((fill[5:3] == 3'b111) && !spill) begin
          cmd.byte_sel = SEL_LEN;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        if (fill == 6'd63) begin
          cmd.load_work = 1'b1;
          state_next    = S_COMP;
          lastblk_next  = sent80 && !spill;
          spill_next    = 1'b0;
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == 6'd63) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (fin && lastblk) begin
          state_next = S_OUT;
          widx_next  = 3'd0;
        end else if (fin) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (m_tready) begin
          if (widx == 3'd7) begin
            cmd.hash_init = 1'b1;
            state_next    = S_IDLE;
            fin_next      = 1'b0;
            sent80_next   = 1'b0;
            spill_next    = 1'b0;
            lastblk_next  = 1'b0;
          end else begin
            widx_next = widx + 3'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      rnd     <= '0;
      widx    <= '0;
      fin     <= 1'b0;
      sent80  <= 1'b0;
      spill   <= 1'b0;
      lastblk <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      rnd     <= rnd_next;
      widx    <= widx_next;
      fin     <= fin_next;
      sent80  <= sent80_next;
      spill   <= spill_next;
      lastblk <= lastblk_next;
    end
  end

  `SHA_ASSERT_NXT(a_comp_end, clk, rst, (state == S_COMP) && (rnd == 6'd63), state == S_UPD)
  `SHA_ASSERT_NXT(a_blk_full, clk, rst, cmd.shift && (fill == 6'd63), (state == S_COMP) && (rnd == 6'd0))
  `SHA_ASSERT_IMP(a_pad_fin, clk, rst, state == S_PAD, fin)
  `SHA_ASSERT_NXT(a_out_done, clk, rst, m_tvalid && m_tready && m_tlast, (state == S_IDLE) && (fill == 6'd0) && !fin)

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One message byte as it goes onto the input stream.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } msg_item_t;

  // One digest word as it should leave the output stream.
  typedef struct {
    logic [31:0] value;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // Round constants and initial hash; entry 0 is the leftmost.
  localparam logic [0:63][31:0] SHA_K = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };
  localparam logic [0:7][31:0] SHA_IV = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam int unsigned WATCHDOG_LIMIT = 5000; // cycles with no word moving
  localparam int unsigned RX_HOLD_CYCLES = 600;  // long receiver hold-off
  localparam int unsigned TAIL_CYCLES    = 300;  // quiet time after the last digest

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
  logic        s_tlast  = 1'b0;   // last_byte
  logic        s_tuser  = 1'b0;   // [0] empty_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] digest_word
  logic        m_tlast;           // last_word
  logic [2:0]  m_tuser;           // [2:0] word_index

  sha256_message_digest_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Digest predictor: its own copy of the chaining value, the partial block,
  // the saturating byte count and the fill level.
  // ---------------------------------------------------------------------------
  logic [31:0] chain [8];
  logic [7:0]  blk_buf [64];
  logic [60:0] byte_count;
  int unsigned blk_fill;

  msg_item_t    msg_items_pending[$];  // bytes waiting for the driver
  digest_word_t digest_words_due[$];   // digest words not yet seen on m_*

  int unsigned err_cnt       = 0;
  int unsigned bytes_hashed  = 0;
  int unsigned msgs_closed   = 0;
  int unsigned words_checked = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_idle_pct  = 0;
  bit          rx_hold_req   = 1'b0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over blk_buf, folded into the chaining value.
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wt;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        // rolling schedule: t-15, t-2 and t-7 modulo 16
        s0 = rotr(w[(t+1)%16], 7) ^ rotr(w[(t+1)%16], 18) ^ (w[(t+1)%16] >> 3);
        s1 = rotr(w[(t+14)%16], 17) ^ rotr(w[(t+14)%16], 19) ^ (w[(t+14)%16] >> 10);
        wt = w[t%16] + s0 + w[(t+9)%16] + s1;
        w[t%16] = wt;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[t] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    byte_count = '0;
    blk_fill   = 0;
  endtask

  // Pad, append the bit length, and queue the eight digest words.
  task automatic close_message();
    logic [63:0]  bit_len;
    digest_word_t dw;
    bit_len = {byte_count, 3'b000};
    blk_buf[blk_fill] = 8'h80;
    for (int i = blk_fill + 1; i < 64; i++) blk_buf[i] = 8'h00;
    if (blk_fill + 9 > 64) begin
      // length does not fit: one more block of zeros
      compress_block();
      for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk_buf[63-i] = bit_len[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.value = chain[i];
      dw.idx   = i[2:0];
      dw.last  = (i == 7);
      digest_words_due = {digest_words_due, dw};
    end
    msgs_closed++;
    restart_digest();
  endtask

  task automatic absorb_word(input logic [7:0] data, input logic last, input logic empty);
    if (empty) begin
      // data and last are ignored; whatever is pending is closed
      close_message();
    end else begin
      blk_buf[blk_fill] = data;
      if (byte_count != {61{1'b1}}) byte_count++;
      blk_fill++;
      bytes_hashed++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
      if (last) close_message();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending byte, holding it until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    msg_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (msg_items_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = msg_items_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.data;
        s_tlast  <= nxt.last;
        s_tuser  <= nxt.empty;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so
  // the core backs up and drops s_tready while bytes are still on offer.
  always @(posedge clk) begin : rcv
    int unsigned hold_left;
    bit          hold_taken;
    if (rst) begin
      m_tready   <= 1'b0;
      hold_left  = 0;
      hold_taken = 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (rx_hold_req && !hold_taken) begin
      m_tready   <= 1'b0;
      hold_left  = RX_HOLD_CYCLES;
      hold_taken = 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input word, checks every accepted
  // digest word against the oldest one due, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    int unsigned  quiet;
    digest_word_t dw;
    if (rst) begin
      quiet = 0;
    end else begin
      quiet++;
      if (s_tvalid && s_tready) begin
        quiet = 0;
        absorb_word(s_tdata, s_tlast, s_tuser);
      end
      if (m_tvalid && m_tready) begin
        quiet = 0;
        if (digest_words_due.size() == 0) begin
          $error("unexpected digest word %h (index %0d)", m_tdata, m_tuser);
          err_cnt++;
        end else begin
          dw = digest_words_due.pop_front();
          words_checked++;
          if (m_tdata !== dw.value) begin
            $error("digest_word: expected %h, got %h", dw.value, m_tdata);
            err_cnt++;
          end
          if (m_tuser !== dw.idx) begin
            $error("word_index: expected %0d, got %0d", dw.idx, m_tuser);
            err_cnt++;
          end
          if (m_tlast !== dw.last) begin
            $error("last_word: expected %0b, got %0b", dw.last, m_tlast);
            err_cnt++;
          end
        end
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [7:0] data, input logic last, input logic empty);
    msg_item_t it;
    it.data  = data;
    it.last  = last;
    it.empty = empty;
    msg_items_pending = {msg_items_pending, it};
  endtask

  // A message of random bytes, ended either by last on its final byte or
  // by a separate empty-flag word (which always ends a zero-length one).
  task automatic push_message(input int unsigned nbytes, input bit flag_close);
    for (int unsigned i = 0; i < nbytes; i++)
      push_word(8'($urandom_range(255)), (i == nbytes - 1) && !flag_close, 1'b0);
    if (flag_close || nbytes == 0)
      push_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  // Short random messages until about budget words are queued.
  task automatic push_random_phase(input int unsigned budget);
    int unsigned nwords, r, len;
    bit          flag_close;
    nwords = 0;
    while (nwords < budget) begin
      r = $urandom_range(99);
      if (r < 15)      len = 0;
      else if (r < 45) len = $urandom_range(3, 1);
      else             len = $urandom_range(20, 4);
      flag_close = (len != 0) && ($urandom_range(3) == 0);
      push_message(len, flag_close);
      nwords += (flag_close || len == 0) ? len + 1 : len;
    end
  endtask

  // One message on a padding boundary: length just fits, spills into a
  // second block, fills a whole block, or runs one byte past it.
  task automatic push_boundary_message();
    int unsigned len;
    case ($urandom_range(5))
      0:       len = 55;
      1:       len = 56;
      2:       len = 57;
      3:       len = 63;
      4:       len = 64;
      default: len = 65;
    endcase
    push_message(len, $urandom_range(3) == 0);
  endtask

  // Sender pause: nothing left to send, nothing in flight, nothing due.
  task automatic wait_drained();
    @(negedge clk);
    while (msg_items_pending.size() != 0 || s_tvalid || digest_words_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    restart_digest();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first idling mix, with the long receiver hold-off right at the start
    src_idle_pct = 28;
    snk_idle_pct = 56;
    rx_hold_req  = 1'b1;

    // directed: empty message (last low, then last high with a full data byte)
    push_word(8'hA5, 1'b0, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    // single-byte messages at the data extremes
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'hFF, 1'b1, 1'b0);
    // "abc"
    push_word(8'h61, 1'b0, 1'b0);
    push_word(8'h62, 1'b0, 1'b0);
    push_word(8'h63, 1'b1, 1'b0);
    // bytes pending, closed by the empty flag with last low
    push_word(8'h12, 1'b0, 1'b0);
    push_word(8'h34, 1'b0, 1'b0);
    push_word(8'hC3, 1'b0, 1'b1);
    // bytes pending, closed by the empty flag with last high; data ignored
    push_word(8'h80, 1'b0, 1'b0);
    push_word(8'h7F, 1'b1, 1'b1);

    push_random_phase(20);
    wait_drained();

    src_idle_pct = 56;
    snk_idle_pct = 28;
    push_random_phase(20);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_boundary_message();
    wait_drained();

    // let any stray output show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Hashed %0d bytes in %0d messages; %0d digest words checked.",
             bytes_hashed, msgs_closed, words_checked);
    $display("Included empty messages, flag-closed messages and a padding-boundary length.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
